// File: design/ctdsf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctdsf_pkg
// shared types, constants, decimal split and segment encode helpers for the
// time/date segment formatter
// ----------------------------------------------------------------------------
package ctdsf_pkg;

    typedef enum logic [1:0] {
        HF_24H       = 2'd0,
        HF_12H       = 2'd1,
        HF_12H_BLANK = 2'd2
    } hour_format_t;

    localparam logic CFG_HOUR_FORMAT = 1'b0;
    localparam logic CFG_DATE_ORDER  = 1'b1;

    localparam logic MODE_TIME = 1'b0;
    localparam logic MODE_DATE = 1'b1;

    localparam logic ORDER_DMY = 1'b0;

    localparam logic [4:0] HOUR_NOON = 5'd12;
    localparam logic [5:0] DATE_DOTS = 6'b010100;
    localparam logic [7:0] DOT_BIT   = 8'h01;
    localparam logic [7:0] SEG_BLANK = 8'h00;

    localparam logic [7:0] SEG_TABLE [10] = '{
        8'b11111100, 8'b01100000, 8'b11011010, 8'b11110010, 8'b01100110,
        8'b10110110, 8'b10111110, 8'b11100000, 8'b11111110, 8'b11110110
    };

    typedef struct packed {
        logic       blank_en;
        logic [5:0] top;
        logic [5:0] mid;
        logic [6:0] low;
        logic [5:0] dots;
    } split_stage_t;

    typedef struct packed {
        logic       blank_en;
        logic [3:0] top_tens;
        logic [3:0] top_ones;
        logic [3:0] mid_tens;
        logic [3:0] mid_ones;
        logic [3:0] low_tens;
        logic [3:0] low_ones;
        logic [5:0] dots;
    } digit_stage_t;

    // tens digit of a 7-bit value by reciprocal multiply
    function automatic logic [3:0] div10(input logic [6:0] v);
        logic [14:0] p;
        p = {8'd0, v} * 15'd205;
        return p[14:11];
    endfunction

    function automatic logic [3:0] mod10(input logic [6:0] v, input logic [3:0] tens);
        logic [6:0] r;
        r = v - ({3'd0, tens} * 7'd10);
        return r[3:0];
    endfunction

    function automatic logic [7:0] encode_digit(input logic [3:0] d);
        return (d < 4'd10) ? SEG_TABLE[d] : SEG_BLANK;
    endfunction

endpackage

// File: design/clock_time_date_segment_formatter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clock_time_date_segment_formatter
// Turns a time (hours, minutes, seconds) or a date (day, month, year) into
// six seven-segment bytes, segment a at bit 7 and the dot at bit 0. Each
// transaction passes three register stages (hour conversion and field
// selection, decimal split, segment encode), and a result is offered once the
// segment encode stage holds it. A new transaction is taken every cycle while
// the output side keeps up; a stall holds each occupied stage while empty
// stages fill. Configuration must be written through cfg_we/cfg_index/cfg_data
// only while no transaction is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module clock_time_date_segment_formatter
    import ctdsf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [1:0] cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       mode,
    input  logic [4:0] high_value,
    input  logic [5:0] mid_value,
    input  logic [6:0] low_value,
    input  logic [5:0] dot_mask,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] digit0,
    output logic [7:0] digit1,
    output logic [7:0] digit2,
    output logic [7:0] digit3,
    output logic [7:0] digit4,
    output logic [7:0] digit5
);

    logic [1:0]   hour_format_reg;
    logic         date_order_reg;

    logic         s1_valid_reg;
    split_stage_t s1_reg;
    split_stage_t s1_next;
    logic         s2_valid_reg;
    digit_stage_t s2_reg;
    digit_stage_t s2_next;
    logic         s3_valid_reg;
    logic [7:0]   dig_reg [6];
    logic [7:0]   dig_next [6];

    logic         s1_ready;
    logic         s2_ready;
    logic         s3_ready;
    logic [4:0]   hour;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hour_format_reg <= HF_24H;
            date_order_reg  <= ORDER_DMY;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_HOUR_FORMAT: hour_format_reg <= cfg_data;
                CFG_DATE_ORDER:  date_order_reg  <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    assign s3_ready = !s3_valid_reg || out_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    // stage 1: hour conversion and field selection
    always_comb
    begin
        hour = high_value;
        if (hour_format_reg != HF_24H)
        begin
            if (high_value > HOUR_NOON)
                hour = high_value - HOUR_NOON;
            else if (high_value == 5'd0)
                hour = HOUR_NOON;
        end
        s1_next.low = low_value;
        if (mode == MODE_TIME)
        begin
            s1_next.blank_en = (hour_format_reg == HF_12H_BLANK);
            s1_next.top      = {1'b0, hour};
            s1_next.mid      = mid_value;
            s1_next.dots     = dot_mask;
        end
        else
        begin
            s1_next.blank_en = 1'b0;
            s1_next.top      = (date_order_reg == ORDER_DMY) ? {1'b0, high_value} : mid_value;
            s1_next.mid      = (date_order_reg == ORDER_DMY) ? mid_value : {1'b0, high_value};
            s1_next.dots     = DATE_DOTS;
        end
    end

    // stage 2: tens and ones digits
    always_comb
    begin
        s2_next.blank_en = s1_reg.blank_en;
        s2_next.dots     = s1_reg.dots;
        s2_next.top_tens = div10({1'b0, s1_reg.top});
        s2_next.mid_tens = div10({1'b0, s1_reg.mid});
        s2_next.low_tens = div10(s1_reg.low);
        s2_next.top_ones = mod10({1'b0, s1_reg.top}, s2_next.top_tens);
        s2_next.mid_ones = mod10({1'b0, s1_reg.mid}, s2_next.mid_tens);
        s2_next.low_ones = mod10(s1_reg.low, s2_next.low_tens);
    end

    // stage 3: segment encode, dots, leading blank
    always_comb
    begin
        dig_next[0] = encode_digit(s2_reg.low_ones);
        dig_next[1] = encode_digit(s2_reg.low_tens);
        dig_next[2] = encode_digit(s2_reg.mid_ones);
        dig_next[3] = encode_digit(s2_reg.mid_tens);
        dig_next[4] = encode_digit(s2_reg.top_ones);
        dig_next[5] = encode_digit(s2_reg.top_tens);
        for (int k = 0; k < 6; k++)
        begin
            if (s2_reg.dots[k])
                dig_next[k] = dig_next[k] | DOT_BIT;
        end
        if (s2_reg.blank_en && (s2_reg.top_tens == 4'd0))
            dig_next[5] = SEG_BLANK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= in_valid;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
            if (s3_ready)
                s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
            s1_reg <= s1_next;
        if (s2_ready && s1_valid_reg)
            s2_reg <= s2_next;
        if (s3_ready && s2_valid_reg)
            dig_reg <= dig_next;
    end

    assign out_valid = s3_valid_reg;
    assign digit0    = dig_reg[0];
    assign digit1    = dig_reg[1];
    assign digit2    = dig_reg[2];
    assign digit3    = dig_reg[3];
    assign digit4    = dig_reg[4];
    assign digit5    = dig_reg[5];

endmodule
